@@ src/scatter_gather_page_coalescer_defines.svh @@
// ----------------------------------------------------------------------------
// Scatter-gather page coalescer assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SCATTER_GATHER_PAGE_COALESCER_DEFINES_SVH
`define SCATTER_GATHER_PAGE_COALESCER_DEFINES_SVH

// same-cycle implication
`define SGPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scatter_gather_page_coalescer: same-cycle check failed");

// next-cycle implication
`define SGPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scatter_gather_page_coalescer: next-cycle check failed");

`endif

@@ src/sgpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Scatter-gather page coalescer package
// Widths, register codes, payload and command types shared by the block.
// ----------------------------------------------------------------------------
package sgpc_pkg;

   localparam int ADDR_W    = 52;
   localparam int LEN_W     = 34;
   localparam int CNT_W     = 13;
   localparam int SHIFT_W   = 5;
   localparam int MASK_W    = 21;
   localparam int SUM_W     = ADDR_W + 1;
   localparam int CSR_IDX_W = 2;

   localparam int MAX_PAGES = 4096;
   localparam int CAP_INT   = (MAX_PAGES < 8191) ? MAX_PAGES : 8191;

   localparam logic [CNT_W-1:0]   COUNT_CAP   = CNT_W'(CAP_INT);
   localparam logic [LEN_W-1:0]   LEN_MAX     = {LEN_W{1'b1}};
   localparam logic [SHIFT_W-1:0] SHIFT_MIN   = SHIFT_W'(9);
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = SHIFT_W'(21);
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(12);
   localparam logic [CNT_W-1:0]   LIMIT_RESET = CNT_W'(4096);

   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_ONLY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SHIFT  = 2'd2;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = 1;
   localparam int FIFO_CNT_W = 2;

   typedef struct packed {
      logic [ADDR_W-1:0] page_address;
      logic              last_page;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] entry_address;
      logic [LEN_W-1:0]  entry_length;
      logic [CNT_W-1:0]  entry_count;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic               close_valid;
      logic [ADDR_W-1:0]  close_start;
      logic [LEN_W-1:0]   close_length;
      logic [ADDR_W-1:0]  final_start;
      logic [LEN_W-1:0]   final_length;
      logic               last;
      logic               count_only;
      logic [CNT_W-1:0]   entry_limit;
      logic [SHIFT_W-1:0] page_shift;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] entries;
      logic             final_done;
   } status_type;

   function automatic logic [MASK_W-1:0] page_mask(input logic [SHIFT_W-1:0] shift);
      page_mask = (MASK_W'(1) << shift) - MASK_W'(1);
   endfunction

   // trim the in-page offset of the first entry's start
   function automatic logic [LEN_W-1:0] trim_length(input logic [LEN_W-1:0]   len,
                                                    input logic [ADDR_W-1:0]  start,
                                                    input logic [SHIFT_W-1:0] shift,
                                                    input logic               first);
      logic [MASK_W-1:0] offset;
      offset = start[MASK_W-1:0] & page_mask(shift);
      trim_length = first ? (len - LEN_W'(offset)) : len;
   endfunction

endpackage

@@ src/sgpc_front.sv @@
// ----------------------------------------------------------------------------
// Scatter-gather page coalescer front end
// Accepts pages, tracks the open run and issues close/final commands.
// ----------------------------------------------------------------------------
module sgpc_front import sgpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   input  logic               cfg_count_only,
   input  logic [CNT_W-1:0]   cfg_entry_limit,
   input  logic [SHIFT_W-1:0] cfg_page_shift,
   output logic               push_valid,
   input  logic               push_ready,
   output cmd_type            push_cmd
);

   logic [ADDR_W-1:0] run_start_ff, run_start_in;
   logic [LEN_W-1:0]  run_length_ff, run_length_in;
   logic [ADDR_W-1:0] previous_page_ff, previous_page_in;
   logic              run_open_ff, run_open_in;

   logic [SHIFT_W-1:0] shift;
   logic [LEN_W-1:0]   psize;
   logic [SUM_W-1:0]   adj_sum;
   logic [LEN_W:0]     len_sum;
   logic               merge;
   logic [ADDR_W-1:0]  new_start;
   logic [LEN_W-1:0]   new_length;
   logic               accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      shift = cfg_page_shift;
      if (cfg_page_shift < SHIFT_MIN) begin
         shift = SHIFT_MIN;
      end else if (cfg_page_shift > SHIFT_MAX) begin
         shift = SHIFT_MAX;
      end
      psize   = LEN_W'(1) << shift;
      adj_sum = {1'b0, previous_page_ff} + SUM_W'(psize);
      len_sum = {1'b0, run_length_ff} + {1'b0, psize};
      merge   = run_open_ff &&
                ((adj_sum == {1'b0, req_data.page_address}) ||
                 ((previous_page_ff == '0) && (req_data.page_address == '0)));
      if (merge) begin
         new_start  = run_start_ff;
         new_length = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
      end else begin
         new_start  = req_data.page_address;
         new_length = psize;
      end

      push_cmd.close_valid  = run_open_ff && !merge;
      push_cmd.close_start  = run_start_ff;
      push_cmd.close_length = run_length_ff;
      push_cmd.final_start  = new_start;
      push_cmd.final_length = new_length;
      push_cmd.last         = req_data.last_page;
      push_cmd.count_only   = cfg_count_only;
      push_cmd.entry_limit  = cfg_entry_limit;
      push_cmd.page_shift   = shift;

      run_start_in     = run_start_ff;
      run_length_in    = run_length_ff;
      previous_page_in = previous_page_ff;
      run_open_in      = run_open_ff;
      if (accept) begin
         if (req_data.last_page) begin
            run_start_in     = '0;
            run_length_in    = '0;
            previous_page_in = '0;
            run_open_in      = 1'b0;
         end else begin
            run_start_in     = new_start;
            run_length_in    = new_length;
            previous_page_in = req_data.page_address;
            run_open_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_start_ff     <= '0;
         run_length_ff    <= '0;
         previous_page_ff <= '0;
         run_open_ff      <= 1'b0;
      end else begin
         run_start_ff     <= run_start_in;
         run_length_ff    <= run_length_in;
         previous_page_ff <= previous_page_in;
         run_open_ff      <= run_open_in;
      end
   end

endmodule

@@ src/sgpc_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// Scatter-gather page coalescer command queue
// Short queue decoupling the front end from the entry emitter.
// ----------------------------------------------------------------------------
module sgpc_cmd_fifo import sgpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  cmd_type               push_cmd,
   output logic                  pop_valid,
   input  logic                  pop,
   output cmd_type               pop_cmd,
   output logic [FIFO_CNT_W-1:0] fill
);

   cmd_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign fill       = count_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? (wr_ptr_ff + FIFO_PTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? (rd_ptr_ff + FIFO_PTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ src/sgpc_back.sv @@
// ----------------------------------------------------------------------------
// Scatter-gather page coalescer back end
// Counts entries, applies the limit and first-entry trim, emits results.
// ----------------------------------------------------------------------------
module sgpc_back import sgpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   output status_type status
);

   typedef enum logic [1:0] {
      PH_CLOSE = 2'b01,
      PH_FINAL = 2'b10
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] entries_ff, entries_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             doing_close;
   logic             limit_ok;
   logic             first;
   logic [CNT_W-1:0] bumped;
   logic             emit;
   logic             out_free;
   logic             go;
   rsp_type          result;
   phase_type        phase_next;
   logic [CNT_W-1:0] entries_next;
   logic             retire;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      doing_close  = head.close_valid && (phase_ff == PH_CLOSE);
      limit_ok     = entries_ff < head.entry_limit;
      first        = (entries_ff == '0);
      bumped       = (entries_ff < COUNT_CAP) ? (entries_ff + CNT_W'(1)) : entries_ff;
      emit         = 1'b0;
      retire       = 1'b0;
      phase_next   = phase_ff;
      entries_next = entries_ff;
      result       = '0;

      if (doing_close) begin
         if (head.count_only) begin
            entries_next = bumped;
         end else if (limit_ok) begin
            emit                 = 1'b1;
            entries_next         = bumped;
            result.entry_address = head.close_start;
            result.entry_length  = trim_length(head.close_length, head.close_start,
                                               head.page_shift, first);
            result.entry_count   = entries_ff;
         end
         if (head.last) begin
            phase_next = PH_FINAL;
         end else begin
            retire = 1'b1;
         end
      end else if (!head.last) begin
         retire = 1'b1;
      end else begin
         emit               = 1'b1;
         retire             = 1'b1;
         phase_next         = PH_CLOSE;
         entries_next       = '0;
         result.last_result = 1'b1;
         if (head.count_only) begin
            result.entry_count = bumped;
         end else if (limit_ok) begin
            result.entry_address = head.final_start;
            result.entry_length  = trim_length(head.final_length, head.final_start,
                                               head.page_shift, first);
            result.entry_count   = entries_ff;
         end else begin
            result.entry_count = entries_ff;
         end
      end

      go  = head_valid && (!emit || out_free);
      pop = go && retire;

      phase_in     = go ? phase_next : phase_ff;
      entries_in   = go ? entries_next : entries_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (go && emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end

      status.entries    = entries_ff;
      status.final_done = go && !doing_close && head.last;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CLOSE;
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         entries_ff   <= entries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/scatter_gather_page_coalescer.sv @@
// ----------------------------------------------------------------------------
// Scatter-gather page coalescer
// Merges a stream of physical page addresses into scatter-gather entries.
// ----------------------------------------------------------------------------
// One page address is accepted every clock cycle while the command queue has
// room. The front end compares each page with the previous one in the same
// cycle and pushes one command into a two-entry queue; the back end retires
// one command per cycle into a single registered result stage while that stage
// is free. A page that both closes a run and ends the buffer produces up to two
// results in a close pass and a final pass; every other page takes one pass.
// Configuration writes take effect on the next accepted page.
`include "scatter_gather_page_coalescer_defines.svh"

module scatter_gather_page_coalescer import sgpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_write_data
);

   logic               count_only_ff, count_only_in;
   logic [CNT_W-1:0]   entry_limit_ff, entry_limit_in;
   logic [SHIFT_W-1:0] page_shift_ff, page_shift_in;

   logic                  push_valid;
   logic                  push_ready;
   cmd_type               push_cmd;
   logic                  head_valid;
   logic                  pop;
   cmd_type               head;
   logic [FIFO_CNT_W-1:0] fill;
   status_type            status;

   always_comb begin
      count_only_in  = count_only_ff;
      entry_limit_in = entry_limit_ff;
      page_shift_in  = page_shift_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_COUNT_ONLY:  count_only_in  = csr_write_data[0];
            CSR_ENTRY_LIMIT: entry_limit_in = csr_write_data;
            CSR_PAGE_SHIFT:  page_shift_in  = csr_write_data[SHIFT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_only_ff  <= 1'b0;
         entry_limit_ff <= LIMIT_RESET;
         page_shift_ff  <= SHIFT_RESET;
      end else begin
         count_only_ff  <= count_only_in;
         entry_limit_ff <= entry_limit_in;
         page_shift_ff  <= page_shift_in;
      end
   end

   sgpc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .cfg_count_only  (count_only_ff),
      .cfg_entry_limit (entry_limit_ff),
      .cfg_page_shift  (page_shift_ff),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_cmd        (push_cmd)
   );

   sgpc_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (head_valid),
      .pop        (pop),
      .pop_cmd    (head),
      .fill       (fill)
   );

   sgpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .status     (status)
   );

   `SGPC_ASSERT_IMPL(a_accept_has_room, clock, reset, req_valid && req_ready, fill < FIFO_CNT_W'(FIFO_DEPTH))
   `SGPC_ASSERT_IMPL(a_entry_not_empty, clock, reset, rsp_valid && !rsp_data.last_result, rsp_data.entry_length != '0)
   `SGPC_ASSERT_IMPL(a_count_capped, clock, reset, 1'b1, status.entries <= COUNT_CAP)
   `SGPC_ASSERT_NEXT(a_count_cleared, clock, reset, status.final_done, status.entries == '0)

endmodule

@@ verif/sgpc_entry_checker.sv @@
// ----------------------------------------------------------------------------
// Scatter-gather entry checker
// Watches the page, entry and register ports of the coalescer, merges each
// accepted page into runs on its own, queues the entries those runs should
// produce and compares every accepted entry, field by field, with the oldest.
// ----------------------------------------------------------------------------
module sgpc_entry_checker import sgpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_write_data,
   output int                   mismatch_count,
   output int                   entries_owed
);

   logic               cfg_count_only;
   logic [CNT_W-1:0]   cfg_entry_limit;
   logic [SHIFT_W-1:0] cfg_page_shift;

   logic [ADDR_W-1:0]  run_base;
   logic [LEN_W-1:0]   run_bytes;
   logic [ADDR_W-1:0]  prior_page;
   logic [CNT_W-1:0]   entries_seen;
   logic               run_active;

   rsp_type            pending_entries[$];
   int                 faults;

   function automatic logic [CNT_W-1:0] bumped(input logic [CNT_W-1:0] n);
      return (n < COUNT_CAP) ? n + 1'b1 : n;
   endfunction

   task automatic queue_entry(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
                              input logic [CNT_W-1:0] cnt, input logic last);
      rsp_type e;
      e.entry_address = addr;
      e.entry_length  = len;
      e.entry_count   = cnt;
      e.last_result   = last;
      pending_entries.push_back(e);
   endtask

   task automatic close_run(input logic [ADDR_W:0] page_bytes, input logic last,
                            output logic made);
      logic [LEN_W-1:0] bytes;
      made = 1'b0;
      if (cfg_count_only) begin
         entries_seen = bumped(entries_seen);
      end else if (entries_seen < cfg_entry_limit) begin
         bytes = run_bytes;
         // trim the in-page offset of the first entry
         if (entries_seen == '0)
            bytes = bytes - LEN_W'(run_base & (page_bytes[ADDR_W-1:0] - 1'b1));
         queue_entry(run_base, bytes, entries_seen, last);
         entries_seen = bumped(entries_seen);
         made = 1'b1;
      end
   endtask

   task automatic merge_page(input req_type r);
      logic [SHIFT_W-1:0] shift;
      logic [ADDR_W:0]    page_bytes;
      logic [ADDR_W:0]    next_addr;
      logic [LEN_W:0]     grown;
      logic               made;
      shift = (cfg_page_shift < SHIFT_MIN) ? SHIFT_MIN :
              (cfg_page_shift > SHIFT_MAX) ? SHIFT_MAX : cfg_page_shift;
      page_bytes = (ADDR_W+1)'(1) << shift;
      next_addr  = {1'b0, prior_page} + page_bytes;
      if (run_active && (next_addr == {1'b0, r.page_address} ||
                         (prior_page == '0 && r.page_address == '0))) begin
         grown     = {1'b0, run_bytes} + page_bytes[LEN_W:0];
         run_bytes = (grown > {1'b0, LEN_MAX}) ? LEN_MAX : grown[LEN_W-1:0];
      end else begin
         if (run_active)
            close_run(page_bytes, 1'b0, made);
         run_base   = r.page_address;
         run_bytes  = page_bytes[LEN_W-1:0];
         run_active = 1'b1;
      end
      prior_page = r.page_address;
      if (r.last_page) begin
         if (cfg_count_only) begin
            entries_seen = bumped(entries_seen);
            queue_entry('0, '0, entries_seen, 1'b1);
         end else begin
            close_run(page_bytes, 1'b1, made);
            if (!made)
               queue_entry('0, '0, entries_seen, 1'b1);
         end
         run_base     = '0;
         run_bytes    = '0;
         prior_page   = '0;
         entries_seen = '0;
         run_active   = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         cfg_count_only  = 1'b0;
         cfg_entry_limit = LIMIT_RESET;
         cfg_page_shift  = SHIFT_RESET;
         run_base        = '0;
         run_bytes       = '0;
         prior_page      = '0;
         entries_seen    = '0;
         run_active      = 1'b0;
         faults          = 0;
         pending_entries.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_COUNT_ONLY:  cfg_count_only  = csr_write_data[0];
               CSR_ENTRY_LIMIT: cfg_entry_limit = csr_write_data;
               CSR_PAGE_SHIFT:  cfg_page_shift  = csr_write_data[SHIFT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            merge_page(req_data);
         if (rsp_valid && rsp_ready) begin
            if (pending_entries.size() == 0) begin
               faults++;
               $display("%0t: unexpected entry: expected none, actual addr=%h len=%h count=%0d last=%b",
                        $time, rsp_data.entry_address, rsp_data.entry_length,
                        rsp_data.entry_count, rsp_data.last_result);
            end else begin
               e = pending_entries.pop_front();
               if (rsp_data !== e) begin
                  faults++;
                  $display("%0t: entry mismatch: expected addr=%h len=%h count=%0d last=%b, %s",
                           $time, e.entry_address, e.entry_length, e.entry_count,
                           e.last_result,
                           $sformatf("actual addr=%h len=%h count=%0d last=%b",
                                     rsp_data.entry_address, rsp_data.entry_length,
                                     rsp_data.entry_count, rsp_data.last_result));
               end
            end
         end
      end
      mismatch_count <= faults;
      entries_owed   <= pending_entries.size();
   end

endmodule

@@ verif/tb_scatter_gather_page_coalescer.sv @@
// ----------------------------------------------------------------------------
// Scatter-gather page coalescer testbench
// Feeds page streams with adjacent, uncommitted, wrapping and random pages
// under several register settings and random back-pressure, including one
// long receiver stall; the entry checker beside the block judges every entry.
// ----------------------------------------------------------------------------
module tb_scatter_gather_page_coalescer;
   import sgpc_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CNT_W-1:0]     csr_write_data;
   int                   mismatch_count;
   int                   entries_owed;

   logic                 hold_off_req  = 1'b0;
   logic                 hold_off_done = 1'b0;
   logic [SHIFT_W-1:0]   shift_now     = SHIFT_RESET;
   logic [ADDR_W-1:0]    last_sent     = '0;

   scatter_gather_page_coalescer DUT (.*);

   sgpc_entry_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("tb_scatter_gather_page_coalescer: errors");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [ADDR_W-1:0] page_span();
      logic [SHIFT_W-1:0] s;
      s = (shift_now < SHIFT_MIN) ? SHIFT_MIN : (shift_now > SHIFT_MAX) ? SHIFT_MAX : shift_now;
      return ADDR_W'(1) << s;
   endfunction

   task automatic send_page(input logic [ADDR_W-1:0] addr, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{page_address: addr, last_page: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      last_sent = addr;
   endtask

   task automatic drain(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (entries_owed != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic configure(input logic co, input logic [CNT_W-1:0] limit,
                            input logic [SHIFT_W-1:0] shift);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_COUNT_ONLY;
      csr_write_data   <= {(CNT_W-1)'($urandom), co};
      @(posedge clock);
      csr_index        <= CSR_ENTRY_LIMIT;
      csr_write_data   <= limit;
      @(posedge clock);
      csr_index        <= CSR_PAGE_SHIFT;
      csr_write_data   <= {(CNT_W-SHIFT_W)'($urandom), shift};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shift_now = shift;
   endtask

   task automatic send_buffer(input int pages);
      logic [ADDR_W-1:0] span;
      logic [ADDR_W-1:0] addr;
      int                r;
      span = page_span();
      for (int k = 0; k < pages; k++) begin
         r = $urandom_range(0, 99);
         if (k > 0 && r < 45)
            addr = last_sent + span;
         else if (r < 60)
            addr = '0;
         else if (r < 65)
            addr = {ADDR_W{1'b1}} & ~(span - 1'b1);
         else if (r < 75)
            addr = ADDR_W'({$urandom, $urandom}) & ~(span - 1'b1);
         else
            addr = ADDR_W'({$urandom, $urandom});
         send_page(addr, k == pages - 1);
      end
   endtask

   initial begin
      int gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req && !hold_off_done) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   initial begin
      logic               co;
      logic [CNT_W-1:0]   limit;
      logic [SHIFT_W-1:0] shift;
      int                 sent;
      int                 len;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_COUNT_ONLY;
      csr_write_data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unaligned start, adjacent run, uncommitted pages, top page then zero
      send_page(52'h0_0012_3456_7123, 1'b0);
      send_page(52'h0_0012_3456_8123, 1'b0);
      send_page(52'h0_0012_3456_9123, 1'b0);
      send_page('0, 1'b0);
      send_page('0, 1'b0);
      send_page('0, 1'b0);
      send_page(52'hF_FFFF_FFFF_F000, 1'b0);
      send_page('0, 1'b1);
      send_page({ADDR_W{1'b1}}, 1'b1);
      send_page('0, 1'b1);
      drain(8);

      // limit of one drops the final run, shift below range
      configure(1'b0, CNT_W'(1), SHIFT_W'(0));
      send_page(52'h200, 1'b0);
      send_page(52'h400, 1'b0);
      send_page(52'h10000, 1'b1);
      drain(8);

      // zero limit, shift above range
      configure(1'b0, '0, SHIFT_W'(31));
      send_page(52'h1234, 1'b0);
      send_page(52'h5, 1'b1);
      drain(8);

      configure(1'b1, LIMIT_RESET, SHIFT_RESET);
      send_page(52'h1000, 1'b0);
      send_page(52'h2000, 1'b0);
      send_page('0, 1'b0);
      send_page('0, 1'b0);
      send_page(52'h9000, 1'b1);
      drain(8);

      for (int p = 0; p < 12; p++) begin
         co    = ($urandom_range(0, 3) == 0);
         limit = CNT_W'($urandom_range(1, 12));
         shift = SHIFT_W'($urandom_range(10, 20));
         case ($urandom_range(0, 5))
            0: limit = CNT_W'(1);
            1: limit = '0;
            2: limit = LIMIT_RESET;
            3: limit = {CNT_W{1'b1}};
            default: ;
         endcase
         case ($urandom_range(0, 4))
            0: shift = SHIFT_MIN;
            1: shift = SHIFT_MAX;
            2: shift = SHIFT_W'($urandom_range(0, 31));
            default: ;
         endcase
         if (p == 0) begin
            co = 1'b0; limit = CNT_W'(1); shift = SHIFT_MIN;
         end else if (p == 1) begin
            co = 1'b0; limit = {CNT_W{1'b1}}; shift = SHIFT_MAX;
         end else if (p == 3) begin
            co = 1'b0; limit = LIMIT_RESET; shift = SHIFT_RESET;
            hold_off_req = 1'b1;
         end
         configure(co, limit, shift);
         sent = 0;
         while (sent < 55) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_buffer(len);
            sent += len;
         end
         drain(8);
      end

      drain(20);
      if (mismatch_count == 0 && entries_owed == 0)
         $display("tb_scatter_gather_page_coalescer: clean");
      else
         $display("tb_scatter_gather_page_coalescer: errors");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/sgpc_pkg.sv
src/sgpc_front.sv
src/sgpc_cmd_fifo.sv
src/sgpc_back.sv
src/scatter_gather_page_coalescer.sv
verif/sgpc_entry_checker.sv
verif/tb_scatter_gather_page_coalescer.sv
